// File: rtl/core/lsh_pkg.sv
// Shared types, constants and the sharpen kernel for the Laplacian sharpen block.
package lsh_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);

    localparam int DIM_W      = 12;     // geometry register width
    localparam int POS_W      = 11;     // row / column position width
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
    localparam logic [DIM_W-1:0] MAX_DIM_W    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_DIM_H    = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] WIDTH_RST    = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST   = DIM_W'(480);
    localparam logic [PIX_W-1:0] EDGE_RST     = 24'hFF0000;
    localparam logic [PIX_W-1:0] LEFT_RST     = 24'h00FF00;

    localparam logic signed [11:0] KERNEL_GAIN = 12'sd5;
    localparam logic signed [11:0] CH_MAX      = 12'sd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_EDGE_COLOR   = 2'd2,
        REG_LEFT_COLOR   = 2'd3
    } cfg_reg_t;

    // effective (clamped) geometry and border colors
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PIX_W-1:0] edge_color;
        logic [PIX_W-1:0] left_color;
    } cfg_t;

    // accepted pixel with its position and border decisions
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             has_prev;   // pixel above is completed now
        logic             prev_left;  // column zero
        logic             prev_edge;  // first row or last column above
        logic             has_last;   // this is the last row
    } s1_item_t;

    // line store read data for the accepted pixel's column
    typedef struct packed {
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] up;
    } lines_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } res_item_t;

    function automatic logic [PIX_W-1:0] sharpen_px(
        input logic [PIX_W-1:0] ctr,
        input logic [PIX_W-1:0] lf,
        input logic [PIX_W-1:0] rt,
        input logic [PIX_W-1:0] up,
        input logic [PIX_W-1:0] dn
    );
        logic signed [11:0] v;
        logic [PIX_W-1:0]   res;
        res = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            v = $signed({4'b0, ctr[CH_W*k +: CH_W]}) * KERNEL_GAIN
              - $signed({4'b0, lf[CH_W*k +: CH_W]})
              - $signed({4'b0, rt[CH_W*k +: CH_W]})
              - $signed({4'b0, up[CH_W*k +: CH_W]})
              - $signed({4'b0, dn[CH_W*k +: CH_W]});
            if (v < 12'sd0) begin
                res[CH_W*k +: CH_W] = '0;
            end
            else if (v > CH_MAX) begin
                res[CH_W*k +: CH_W] = '1;
            end
            else begin
                res[CH_W*k +: CH_W] = v[CH_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/lsh_cfg_regs.sv
// Configuration register file with clamped geometry outputs.
module lsh_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lsh_pkg::cfg_t                    cfg
);

    logic [lsh_pkg::DIM_W-1:0] width_reg,  width_next;
    logic [lsh_pkg::DIM_W-1:0] height_reg, height_next;
    logic [lsh_pkg::PIX_W-1:0] edge_reg,   edge_next;
    logic [lsh_pkg::PIX_W-1:0] left_reg,   left_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        edge_next   = edge_reg;
        left_next   = left_reg;
        if (cfg_valid) begin
            case (lsh_pkg::cfg_reg_t'(cfg_index))
                lsh_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data[lsh_pkg::DIM_W-1:0];
                lsh_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data[lsh_pkg::DIM_W-1:0];
                lsh_pkg::REG_EDGE_COLOR:   edge_next   = cfg_data[lsh_pkg::PIX_W-1:0];
                lsh_pkg::REG_LEFT_COLOR:   left_next   = cfg_data[lsh_pkg::PIX_W-1:0];
                default:                   width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= lsh_pkg::WIDTH_RST;
            height_reg <= lsh_pkg::HEIGHT_RST;
            edge_reg   <= lsh_pkg::EDGE_RST;
            left_reg   <= lsh_pkg::LEFT_RST;
        end
        else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            edge_reg   <= edge_next;
            left_reg   <= left_next;
        end
    end

    always_comb
    begin
        if (width_reg < lsh_pkg::MIN_DIM) begin
            cfg.width = lsh_pkg::MIN_DIM;
        end
        else if (width_reg > lsh_pkg::MAX_DIM_W) begin
            cfg.width = lsh_pkg::MAX_DIM_W;
        end
        else begin
            cfg.width = width_reg;
        end
        if (height_reg < lsh_pkg::MIN_DIM) begin
            cfg.height = lsh_pkg::MIN_DIM;
        end
        else if (height_reg > lsh_pkg::MAX_DIM_H) begin
            cfg.height = lsh_pkg::MAX_DIM_H;
        end
        else begin
            cfg.height = height_reg;
        end
        cfg.edge_color = edge_reg;
        cfg.left_color = left_reg;
    end

endmodule

// File: rtl/core/lsh_line_buf.sv
// Two line stores (rows r-2 and r-1) with registered reads.
module lsh_line_buf (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [lsh_pkg::LINE_AW-1:0]      rd_addr,
    input  logic                             wr_en,
    input  logic [lsh_pkg::LINE_AW-1:0]      wr_addr,
    input  logic [lsh_pkg::PIX_W-1:0]        wr_data,
    output lsh_pkg::lines_t                  lines
);

    logic [lsh_pkg::PIX_W-1:0] newer_mem [lsh_pkg::MAX_WIDTH];
    logic [lsh_pkg::PIX_W-1:0] older_mem [lsh_pkg::MAX_WIDTH];

    logic [lsh_pkg::PIX_W-1:0] mid_reg;
    logic [lsh_pkg::PIX_W-1:0] right_reg;
    logic [lsh_pkg::PIX_W-1:0] up_reg;
    logic [lsh_pkg::LINE_AW-1:0] rd_addr_p1;

    // beyond the last column this reads a stale entry; it is never used there
    assign rd_addr_p1 = rd_addr + lsh_pkg::LINE_AW'(1);

    // the row moves down: older takes what newer held, newer takes the pixel
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            newer_mem[wr_addr] <= wr_data;
            older_mem[wr_addr] <= mid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            mid_reg   <= newer_mem[rd_addr];
            right_reg <= newer_mem[rd_addr_p1];
            up_reg    <= older_mem[rd_addr];
        end
    end

    assign lines.mid   = mid_reg;
    assign lines.right = right_reg;
    assign lines.up    = up_reg;

endmodule

// File: rtl/core/lsh_result_q.sv
// Kernel evaluation and two-entry result register feeding the output stream.
module lsh_result_q (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsh_pkg::cfg_t                     cfg,
    input  logic                              s1_valid,
    input  lsh_pkg::s1_item_t                 s1,
    input  lsh_pkg::lines_t                   lines,
    input  logic [lsh_pkg::PIX_W-1:0]         left_px,
    output logic                              take,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lsh_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                              out_last
);

    lsh_pkg::res_item_t q0_reg, q0_next;
    lsh_pkg::res_item_t q1_reg, q1_next;
    logic [1:0]         cnt_reg, cnt_next;

    lsh_pkg::res_item_t first_res;
    lsh_pkg::res_item_t second_res;
    logic [lsh_pkg::PIX_W-1:0] prev_px;
    logic [lsh_pkg::PIX_W-1:0] row_border;
    logic [1:0]         n_res;
    logic               out_hs;

    assign out_hs = out_valid && out_ready;
    // load only into an empty queue, or one being drained this cycle
    assign take   = s1_valid && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_hs));

    always_comb
    begin
        if (s1.prev_left) begin
            prev_px = cfg.left_color;
        end
        else if (s1.prev_edge) begin
            prev_px = cfg.edge_color;
        end
        else begin
            prev_px = lsh_pkg::sharpen_px(lines.mid, left_px, lines.right, lines.up, s1.pix);
        end
        row_border = s1.prev_left ? cfg.left_color : cfg.edge_color;

        second_res.row = s1.row;
        second_res.col = s1.col;
        second_res.pix = row_border;
        if (s1.has_prev) begin
            first_res.row = s1.row - lsh_pkg::POS_W'(1);
            first_res.col = s1.col;
            first_res.pix = prev_px;
        end
        else begin
            first_res = second_res;
        end
        n_res = {1'b0, s1.has_prev} + {1'b0, s1.has_last};
    end

    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (take) begin
            q0_next  = first_res;
            q1_next  = second_res;
            cnt_next = n_res;
        end
        else if (out_hs) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end
        else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_last  = (cnt_reg == 2'd1);
    assign out_data  = {2'b00,
                        q0_reg.pix[23:16], q0_reg.pix[15:8], q0_reg.pix[7:0],
                        q0_reg.col, q0_reg.row};

    // a second result only ever comes with a pixel above it
    a_two_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
        take && (n_res == 2'd2) |-> s1.has_prev)
        else $error("two results without a completed pixel above");

endmodule

// File: rtl/core/laplacian_sharpen_3ch.sv
// Top level: streaming 5-point Laplacian sharpen of 3-channel 8-bit pixels.
//
// Pixels enter in raster order on the s_axis stream, one transaction per pixel, and
// up to one pixel is accepted every clock. The arrival of pixel (r,c) with r >= 1
// completes output pixel (r-1,c), which is emitted with its row and column; when r
// is the last row, border pixel (r,c) follows it, so an input on the last row gives
// two output transactions and row 0 gives none. m_axis_tlast marks the last output
// transaction caused by one input. Interior outputs are 5*center minus the four
// neighbors per channel, clamped to 0..255; the first row, last row and last column
// take edge_border_color and the first column, corners included, takes
// left_border_color. Pixels pass the stage and result registers; the single output
// port sends one result at a time, so the input stalls while a last-row pixel's two
// results go out. Storage: two line stores of 2048 x 24 bits, the newer one read at
// two columns per accepting cycle. No clearing pass after reset. Geometry is clamped
// to 3..2048; the user writes it over cfg only while the stream is idle (not enforced).
module laplacian_sharpen_3ch (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input pixels
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lsh_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2
    // result pixels
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lsh_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // out_row, out_col, out_ch0,
                                                              // out_ch1, out_ch2, 2 pad bits
    output logic                              m_axis_tlast    // run_last
);

    lsh_pkg::cfg_t      cfg;
    lsh_pkg::lines_t    lines;
    lsh_pkg::s1_item_t  s1_reg, s1_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_take;

    logic [lsh_pkg::POS_W-1:0] row_reg, row_next;
    logic [lsh_pkg::POS_W-1:0] col_reg, col_next;
    logic [lsh_pkg::PIX_W-1:0] prev_mid_reg, prev_mid_next;

    // position of the pixel that would be accepted now
    logic                      col_wrap;
    logic [lsh_pkg::DIM_W-1:0] row_pre;
    logic [lsh_pkg::POS_W-1:0] eff_row;
    logic [lsh_pkg::POS_W-1:0] eff_col;
    logic [lsh_pkg::DIM_W-1:0] col_inc;
    logic [lsh_pkg::DIM_W-1:0] row_inc;
    logic                      s_accept;

    lsh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage register is free when empty or when its item moves on this cycle
    assign s_axis_tready = !s1_valid_reg || s1_take;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // wrap a counter left past the geometry, then find the following position
    always_comb
    begin
        col_wrap = ({1'b0, col_reg} >= cfg.width);
        row_pre  = col_wrap ? ({1'b0, row_reg} + lsh_pkg::DIM_W'(1)) : {1'b0, row_reg};
        eff_row  = (row_pre >= cfg.height) ? '0 : row_pre[lsh_pkg::POS_W-1:0];
        eff_col  = col_wrap ? '0 : col_reg;
        col_inc  = {1'b0, eff_col} + lsh_pkg::DIM_W'(1);
        row_inc  = {1'b0, eff_row} + lsh_pkg::DIM_W'(1);

        row_next = row_reg;
        col_next = col_reg;
        if (s_accept) begin
            if (col_inc >= cfg.width) begin
                col_next = '0;
                row_next = (row_inc >= cfg.height) ? '0 : row_inc[lsh_pkg::POS_W-1:0];
            end
            else begin
                col_next = col_inc[lsh_pkg::POS_W-1:0];
                row_next = eff_row;
            end
        end
    end

    // stage register: pixel, position and border decisions
    always_comb
    begin
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_next.pix       = s_axis_tdata[lsh_pkg::PIX_W-1:0];
            s1_next.row       = eff_row;
            s1_next.col       = eff_col;
            s1_next.has_prev  = (eff_row != '0);
            s1_next.prev_left = (eff_col == '0);
            s1_next.prev_edge = (eff_row == lsh_pkg::POS_W'(1))
                             || ({1'b0, eff_col} == (cfg.width - lsh_pkg::DIM_W'(1)));
            s1_next.has_last  = ({1'b0, eff_row} == (cfg.height - lsh_pkg::DIM_W'(1)));
            s1_valid_next     = 1'b1;
        end
        else if (s1_take) begin
            s1_valid_next = 1'b0;
        end
        // left neighbor of the next pixel is this pixel's center from the row above
        prev_mid_next = s1_take ? lines.mid : prev_mid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            prev_mid_reg <= '0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            prev_mid_reg <= prev_mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // read the column at accept, write it back when the item leaves the stage
    lsh_line_buf u_lines (
        .clk     (clk),
        .rd_en   (s_accept),
        .rd_addr (eff_col[lsh_pkg::LINE_AW-1:0]),
        .wr_en   (s1_take),
        .wr_addr (s1_reg.col[lsh_pkg::LINE_AW-1:0]),
        .wr_data (s1_reg.pix),
        .lines   (lines)
    );

    lsh_result_q u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s1_valid  (s1_valid_reg),
        .s1        (s1_reg),
        .lines     (lines),
        .left_px   (prev_mid_reg),
        .take      (s1_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach the stage register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_take |=> s1_valid_reg && $stable(s1_reg))
        else $error("stalled stage item changed");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s1_take |-> (eff_col != s1_reg.col))
        else $error("line store read and write hit the same column");

endmodule
